[design/vtp_pkg.sv]
`default_nettype none
package vtp_pkg;
    localparam int ScreenWidth  = 256;
    localparam int ScreenHeight = 256;
    localparam logic [15:0] HalfW = 16'(ScreenWidth / 2);
    localparam logic [15:0] HalfH = 16'(ScreenHeight / 2);
    localparam int QW = 32;   // quotient bits produced by the divider
    localparam logic [1:0] REG_ROW_X = 2'd0;
    localparam logic [1:0] REG_ROW_Y = 2'd1;
    localparam logic [1:0] REG_ROW_Z = 2'd2;

    typedef struct packed {
        logic signed [31:0] xp;
        logic signed [31:0] yp;
        logic signed [15:0] zp;
    } proj_t;

    typedef struct packed {
        logic [15:0] screen_x;
        logic [15:0] screen_y;
        logic [15:0] depth;
        logic        div_fault;
    } result_t;
endpackage
`default_nettype wire

[design/vtp_div.sv]
`default_nettype none
// pipelined restoring divider: magnitudes, one quotient bit per stage
module vtp_div
    import vtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire proj_t       in_data,
    output logic             out_valid,
    output result_t          out_data
);
    logic [QW:0]       v_reg;
    logic [31:0]       rx_reg [QW+1];
    logic [31:0]       ry_reg [QW+1];
    logic [31:0]       qx_reg [QW+1];
    logic [31:0]       qy_reg [QW+1];
    logic [15:0]       d_reg  [QW+1];
    logic              nx_reg [QW+1];
    logic              ny_reg [QW+1];
    logic [15:0]       z_reg  [QW+1];

    logic [31:0] ax, ay;
    logic [15:0] az;
    always_comb
    begin
        ax = in_data.xp[31] ? 32'(-in_data.xp) : in_data.xp;
        ay = in_data.yp[31] ? 32'(-in_data.yp) : in_data.yp;
        az = in_data.zp[15] ? 16'(-in_data.zp) : in_data.zp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QW-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0] <= ax; ry_reg[0] <= ay;
            qx_reg[0] <= '0; qy_reg[0] <= '0;
            d_reg[0]  <= az; z_reg[0] <= in_data.zp;
            nx_reg[0] <= in_data.xp[31] ^ in_data.zp[15];
            ny_reg[0] <= in_data.yp[31] ^ in_data.zp[15];
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        localparam int B = QW - 1 - s;
        logic [47:0] dx, dy;
        logic        tx, ty;
        always_comb
        begin
            dx = {16'd0, rx_reg[s]} >> B;
            dy = {16'd0, ry_reg[s]} >> B;
            tx = dx >= {32'd0, d_reg[s]};
            ty = dy >= {32'd0, d_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[s+1] <= tx ? 32'(rx_reg[s] - ({16'd0, d_reg[s]} << B)) : rx_reg[s];
                ry_reg[s+1] <= ty ? 32'(ry_reg[s] - ({16'd0, d_reg[s]} << B)) : ry_reg[s];
                qx_reg[s+1] <= qx_reg[s] | (32'(tx) << B);
                qy_reg[s+1] <= qy_reg[s] | (32'(ty) << B);
                d_reg[s+1]  <= d_reg[s];
                z_reg[s+1]  <= z_reg[s];
                nx_reg[s+1] <= nx_reg[s];
                ny_reg[s+1] <= ny_reg[s];
            end
        end
    end

    logic [31:0] mx, my;
    logic okx, oky, zero;
    always_comb
    begin
        mx   = qx_reg[QW];
        my   = qy_reg[QW];
        zero = d_reg[QW] == '0;
        okx  = !zero && (nx_reg[QW] ? mx <= 32'd32768 : mx <= 32'd32767);
        oky  = !zero && (ny_reg[QW] ? my <= 32'd32768 : my <= 32'd32767);
        out_valid          = v_reg[QW];
        out_data.screen_x  = (okx ? (nx_reg[QW] ? 16'(-mx) : mx[15:0]) : 16'd0) + HalfW;
        out_data.screen_y  = (oky ? (ny_reg[QW] ? 16'(-my) : my[15:0]) : 16'd0) + HalfH;
        out_data.depth     = z_reg[QW];
        out_data.div_fault = !(okx && oky);
    end
endmodule
`default_nettype wire

[design/vertex_transform_project.sv]
`default_nettype none
// Vertex transform and perspective projection. One vertex per clock unless the
// output stalls; a vertex passes three stages of transform arithmetic (adds, 16x16
// multiplies, row sums) and a 32-stage divider with one quotient bit per stage, plus
// input and output stages. The whole pipe advances when the output register is empty
// or taken, so a stall holds every stage in place. The user writes rows through the
// cfg port (index 0..2) only while no vertex is in flight; the block does not enforce it.
module vertex_transform_project
    import vtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // vx, vy, vz
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,        // screen_x, screen_y, depth, div_fault, pad
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata
);
    logic [63:0] row_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= '0; row_reg[1] <= '0; row_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ROW_X: row_reg[0] <= cfg_wdata;
                REG_ROW_Y: row_reg[1] <= cfg_wdata;
                REG_ROW_Z: row_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic ovalid_reg;
    result_t odata_reg;
    assign en = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = en;

    logic [3:0] v_reg;
    logic signed [15:0] x1_reg, y1_reg, z1_reg;
    // stage 1: sums and operand setup
    logic signed [15:0] a1_reg [3], b1_reg [3], m2_reg [3], t_reg [3];
    logic signed [15:0] m0_reg [3], m1_reg [3];
    logic signed [15:0] xs_reg, ys_reg, zs_reg;
    // stage 2: products
    logic signed [31:0] ab_reg [3], mz_reg [3], xy_reg, mm_reg [3];
    logic signed [15:0] t2_reg [3];
    // stage 3: rows
    proj_t p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= s_axis_tdata[15:0];
            y1_reg <= s_axis_tdata[31:16];
            z1_reg <= s_axis_tdata[47:32];
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a1_reg[r] <= 16'(row_reg[r][15:0] + y1_reg);
                b1_reg[r] <= 16'(row_reg[r][31:16] + x1_reg);
                m0_reg[r] <= row_reg[r][15:0];
                m1_reg[r] <= row_reg[r][31:16];
                m2_reg[r] <= row_reg[r][47:32];
                t_reg[r]  <= row_reg[r][63:48];
                ab_reg[r] <= a1_reg[r] * b1_reg[r];
                mz_reg[r] <= m2_reg[r] * zs_reg;
                mm_reg[r] <= m0_reg[r] * m1_reg[r];
                t2_reg[r] <= t_reg[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs_reg <= x1_reg; ys_reg <= y1_reg; zs_reg <= z1_reg;
            xy_reg <= xs_reg * ys_reg;
        end
    end

    logic signed [31:0] acc [3];
    logic signed [31:0] off [3];
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = ab_reg[r] + mz_reg[r] - xy_reg;
            off[r] = 32'(t2_reg[r]) - (mm_reg[r] >>> 12);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg.xp <= (acc[0] >>> 4) + (off[0] <<< 8);
            p_reg.yp <= (acc[1] >>> 4) + (off[1] <<< 8);
            p_reg.zp <= 16'((acc[2] >>> 12) + off[2]);
        end
    end

    logic    dv;
    result_t dd;
    vtp_div u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v_reg[3]), .in_data(p_reg),
        .out_valid(dv), .out_data(dd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (en)
            ovalid_reg <= dv;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            odata_reg <= dd;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, odata_reg.div_fault, odata_reg.depth,
                            odata_reg.screen_y, odata_reg.screen_x};
endmodule
`default_nettype wire

[design/vtp_checker.sv]
`default_nettype none
module vtp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
        else $error("pad bits set");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");
endmodule

bind vertex_transform_project vtp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

[tb/vertex_transform_project_test.sv]
`timescale 1ns / 100ps
module vertex_transform_project_test;
    import vtp_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int PIPE_LATENCY = 40;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [15:0] vz;
        logic [15:0] vy;
        logic [15:0] vx;
    } vertex_t;

    typedef struct {
        logic [15:0] screen_x;
        logic [15:0] screen_y;
        logic [15:0] depth;
        logic        div_fault;
    } screen_pt_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // vx, vy, vz
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // screen_x, screen_y, depth, div_fault, pad
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [63:0] cfg_wdata;

    logic [63:0] mat_row [3];
    vertex_t     vertex_q [$];
    screen_pt_t  screen_q [$];
    logic        s_fire;
    int          send_idle;
    int          recv_idle;
    int          errors;
    int          cycles;

    vertex_transform_project u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint mword(logic [63:0] r, int k);
        return longint'($signed(r[16*k +: 16]));
    endfunction

    // reduced-multiply row product, wrapped to 32 bits
    function automatic longint row_product(logic [63:0] r, longint x, longint y, longint z);
        longint a;
        longint b;
        a = longint'(shortint'(mword(r, 0) + y));
        b = longint'(shortint'(mword(r, 1) + x));
        return longint'(int'(a * b + mword(r, 2) * z - x * y));
    endfunction

    function automatic longint row_shift(logic [63:0] r);
        return mword(r, 3) - ((mword(r, 0) * mword(r, 1)) >>> 12);
    endfunction

    function automatic screen_pt_t project_vertex(vertex_t v);
        screen_pt_t p;
        longint x, y, z, xp, yp, zp, qx, qy;
        logic okx, oky;
        x = longint'($signed(v.vx));
        y = longint'($signed(v.vy));
        z = longint'($signed(v.vz));
        xp = longint'(int'((row_product(mat_row[0], x, y, z) >>> 4)
                           + row_shift(mat_row[0]) * 256));
        yp = longint'(int'((row_product(mat_row[1], x, y, z) >>> 4)
                           + row_shift(mat_row[1]) * 256));
        zp = longint'(shortint'((row_product(mat_row[2], x, y, z) >>> 12)
                                + longint'(shortint'(row_shift(mat_row[2])))));
        qx = 0;
        qy = 0;
        okx = 1'b0;
        oky = 1'b0;
        if (zp != 0)
        begin
            qx = xp / zp;
            qy = yp / zp;
            okx = (qx >= -32768 && qx <= 32767);
            oky = (qy >= -32768 && qy <= 32767);
            if (!okx)
                qx = 0;
            if (!oky)
                qy = 0;
        end
        p.screen_x = 16'(qx + ScreenWidth / 2);
        p.screen_y = 16'(qy + ScreenHeight / 2);
        p.depth = 16'(zp);
        p.div_fault = !(okx && oky);
        return p;
    endfunction

    // input side: accept, predict
    always @(posedge clk)
    begin
        s_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            screen_q.push_back(project_vertex(vertex_t'(s_axis_tdata)));
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_fire)
        begin
            if (vertex_q.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= vertex_q.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    // output side: compare each transaction with the oldest prediction
    always @(posedge clk)
    begin
        screen_pt_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (screen_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                e = screen_q.pop_front();
                if (m_axis_tdata[15:0] !== e.screen_x)
                begin
                    $display("%0t: screen_x expected %h actual %h", $time, e.screen_x,
                             m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[31:16] !== e.screen_y)
                begin
                    $display("%0t: screen_y expected %h actual %h", $time, e.screen_y,
                             m_axis_tdata[31:16]);
                    errors++;
                end
                if (m_axis_tdata[47:32] !== e.depth)
                begin
                    $display("%0t: depth expected %h actual %h", $time, e.depth,
                             m_axis_tdata[47:32]);
                    errors++;
                end
                if (m_axis_tdata[48] !== e.div_fault)
                begin
                    $display("%0t: div_fault expected %b actual %b", $time, e.div_fault,
                             m_axis_tdata[48]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_row(logic [1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        if (idx != REG_UNUSED)
            mat_row[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (vertex_q.size() > 0 || s_axis_tvalid || screen_q.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_word(bit narrow);
        if (narrow)
            return 16'($urandom_range(4095)) - 16'd2048;
        return 16'($urandom);
    endfunction

    function automatic logic [63:0] sane_row(bit is_z);
        logic [63:0] r;
        r[15:0] = 16'($urandom_range(255)) - 16'd128;
        r[31:16] = 16'($urandom_range(255)) - 16'd128;
        r[47:32] = is_z ? 16'($urandom_range(511)) : 16'($urandom_range(8191)) - 16'd4096;
        r[63:48] = is_z ? 16'($urandom_range(4000)) + 16'd200
                        : 16'($urandom_range(255)) - 16'd128;
        return r;
    endfunction

    task automatic add_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        vertex_t v;
        v.vx = x;
        v.vy = y;
        v.vz = z;
        vertex_q.push_back(v);
    endtask

    initial
    begin
        logic [15:0] ext [4];
        errors = 0;
        cycles = 0;
        send_idle = 19;
        recv_idle = 64;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_ROW_X;
        cfg_wdata = '0;
        mat_row[0] = '0;
        mat_row[1] = '0;
        mat_row[2] = '0;
        ext[0] = 16'h0000;
        ext[1] = 16'h7fff;
        ext[2] = 16'h8000;
        ext[3] = 16'hffff;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset rows: zero depth everywhere
        add_vertex(16'h0001, 16'h0002, 16'h0003);
        add_vertex(16'h7fff, 16'h8000, 16'hffff);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
            begin
                send_idle = 64;
                recv_idle = 19;
            end
            if (ph == 6)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (ph)
                1:
                begin
                    write_row(REG_ROW_X, 64'h8000_8000_8000_8000);
                    write_row(REG_ROW_Y, 64'h7fff_7fff_7fff_7fff);
                    write_row(REG_ROW_Z, 64'h7fff_0000_0000_0000);
                end
                2:
                begin
                    write_row(REG_ROW_X, 64'h7fff_7fff_7fff_7fff);
                    write_row(REG_ROW_Y, 64'h8000_8000_8000_8000);
                    write_row(REG_ROW_Z, 64'h8000_8000_8000_8000);
                end
                5:
                begin
                    write_row(REG_ROW_X, {$urandom, $urandom});
                    write_row(REG_ROW_Y, {$urandom, $urandom});
                    write_row(REG_ROW_Z, {$urandom, $urandom});
                end
                default:
                begin
                    write_row(REG_ROW_X, sane_row(1'b0));
                    write_row(REG_ROW_Y, sane_row(1'b0));
                    write_row(REG_ROW_Z, sane_row(1'b1));
                end
            endcase
            // out-of-range index must leave the rows alone
            write_row(REG_UNUSED, {$urandom, $urandom});
            if (ph < 2)
            begin
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4; j++)
                        add_vertex(ext[i], ext[j], ext[(i + j) % 4]);
                // zero vertex: the row products cancel the shift term, leaving the z translation as depth
                add_vertex(16'h0000, 16'h0000, 16'h0000);
            end
            for (int n = 0; n < 50; n++)
            begin
                bit narrow;
                narrow = ($urandom_range(3) != 0);
                add_vertex(rand_word(narrow), rand_word(narrow), rand_word(narrow));
            end
            drain();
        end

        // zero depth with nonzero x and y rows: an all-zero z row gives zero depth
        write_row(REG_ROW_Z, 64'h0000_0000_0000_0000);
        add_vertex(16'h0100, 16'h0200, 16'h0300);
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
